### rtl/sira_pkg.sv
// Package for the signed integer to radix ASCII converter.
// Holds widths, character codes, the controller/datapath command and status
// types and the digit to character function. Depends on nothing.
`default_nettype none

package sira_pkg;

	localparam int VALUE_W       = 32;
	localparam int RADIX_W       = 6;
	localparam int CHAR_W        = 8;
	localparam int DIGIT_W       = 5;
	localparam int CNT_W         = $clog2(VALUE_W + 1);
	localparam int ADDR_W        = $clog2(VALUE_W);
	localparam int BITS_PER_STEP = 8;
	localparam int STEPS         = (VALUE_W + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int PAD_W         = STEPS * BITS_PER_STEP;
	localparam int STEP_W        = (STEPS > 1) ? $clog2(STEPS) : 1;

	localparam logic [RADIX_W-1:0] RADIX_MIN  = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX  = RADIX_W'(32);
	localparam logic [RADIX_W-1:0] RADIX_SIGN = RADIX_W'(10);

	localparam logic [DIGIT_W-1:0] DIGIT_TEN  = DIGIT_W'(10);
	localparam logic [CHAR_W-1:0]  CHAR_ZERO  = CHAR_W'(48);
	localparam logic [CHAR_W-1:0]  CHAR_ALPHA = CHAR_W'(65);
	localparam logic [CHAR_W-1:0]  CHAR_MINUS = CHAR_W'(45);
	localparam logic [CHAR_W-1:0]  CHAR_NONE  = CHAR_W'(0);

	typedef struct packed {
		logic load_in;
		logic div_step;
		logic div_last;
		logic fix;
		logic rd_en;
		logic idx_dec;
		logic out_bad;
		logic out_sign;
		logic out_digit;
	} sira_cmd_t;

	typedef struct packed {
		logic bad_radix;
		logic q_zero;
		logic cnt_full;
		logic neg10;
		logic out_free;
		logic idx_zero;
	} sira_sts_t;

	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d >= DIGIT_TEN) begin
			c = CHAR_ALPHA + CHAR_W'(d) - CHAR_W'(DIGIT_TEN);
		end else begin
			c = CHAR_ZERO + CHAR_W'(d);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### rtl/sira_if.sv
// Valid/ready channel interfaces for the radix ASCII converter.
// One carries the value and radix in, the other the characters out; uses sira_pkg.
`default_nettype none

interface sira_in_if
	import sira_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic signed [VALUE_W-1:0]  number;
	logic        [RADIX_W-1:0]  radix;

	modport source (output valid, output number, output radix, input ready);
	modport sink   (input valid, input number, input radix, output ready);
endinterface

interface sira_out_if
	import sira_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              last;
	logic              bad_radix;

	modport source (output valid, output char_code, output last, output bad_radix, input ready);
	modport sink   (input valid, input char_code, input last, input bad_radix, output ready);
endinterface

`default_nettype wire

### rtl/sira_ctrl.sv
// Controller state machine of the radix ASCII converter.
// Sequences division, zero fixup and character emission; uses sira_pkg.
`default_nettype none

module sira_ctrl
	import sira_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire sira_sts_t sts,
	output sira_cmd_t      cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DIGIT = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_FIX   = 4'd3;
	localparam logic [3:0] S_BAD   = 4'd4;
	localparam logic [3:0] S_SIGN  = 4'd5;
	localparam logic [3:0] S_RD    = 4'd6;
	localparam logic [3:0] S_WR    = 4'd7;

	logic [3:0]        state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DIGIT;
				end
			end
			S_DIGIT: begin
				priority if (sts.bad_radix) begin
					state_d = S_BAD;
				end else if (sts.q_zero || sts.cnt_full) begin
					state_d = S_FIX;
				end else begin
					step_d  = '0;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_W'(STEPS - 1)) begin
					cmd.div_last = 1'b1;
					state_d      = S_DIGIT;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			S_FIX: begin
				cmd.fix = 1'b1;
				state_d = sts.neg10 ? S_SIGN : S_RD;
			end
			S_BAD: begin
				if (sts.out_free) begin
					cmd.out_bad = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_SIGN: begin
				if (sts.out_free) begin
					cmd.out_sign = 1'b1;
					state_d      = S_RD;
				end
			end
			S_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_WR;
			end
			S_WR: begin
				if (sts.out_free) begin
					cmd.out_digit = 1'b1;
					if (sts.idx_zero) begin
						state_d = S_IDLE;
					end else begin
						cmd.idx_dec = 1'b1;
						state_d     = S_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

endmodule

`default_nettype wire

### rtl/sira_dp.sv
// Datapath of the radix ASCII converter: magnitude, divider, digit store,
// emit index and output register. Driven by sira_ctrl; uses sira_pkg and sira_out_if.
`default_nettype none

module sira_dp
	import sira_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic signed [VALUE_W-1:0] number,
	input  wire logic        [RADIX_W-1:0] radix,
	input  wire sira_cmd_t                 cmd,
	output sira_sts_t                      sts,
	sira_out_if.source                     char_ch
);

	logic [RADIX_W-1:0] radix_q;
	logic               neg10_q;
	logic [PAD_W-1:0]   quot_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ADDR_W-1:0]  idx_q;
	logic [DIGIT_W-1:0] rd_q;
	logic [DIGIT_W-1:0] store [VALUE_W];

	logic               out_valid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;
	logic               bad_q;

	logic [VALUE_W-1:0] mag;
	logic [PAD_W-1:0]   quot_nx;
	logic [DIGIT_W-1:0] rem_nx;
	logic [DIGIT_W:0]   part;
	logic               cnt_zero;
	logic               we;
	logic [ADDR_W-1:0]  wa;
	logic [DIGIT_W-1:0] wd;

	// The negation of the most negative value wraps to 2^(VALUE_W-1), which
	// is the true magnitude when read as unsigned.
	assign mag = number[VALUE_W-1] ? (~number + 1'b1) : number;

	always_comb begin
		part    = {1'b0, rem_q};
		quot_nx = quot_q << BITS_PER_STEP;
		for (int i = 0; i < BITS_PER_STEP; i++) begin
			part = {part[DIGIT_W-1:0], quot_q[PAD_W-1-i]};
			if (part >= radix_q) begin
				part = part - radix_q;
				quot_nx[BITS_PER_STEP-1-i] = 1'b1;
			end
		end
		rem_nx = part[DIGIT_W-1:0];
	end

	assign cnt_zero = (cnt_q == '0);
	assign we       = cmd.div_last || (cmd.fix && cnt_zero);
	assign wa       = cmd.fix ? '0 : cnt_q[ADDR_W-1:0];
	assign wd       = cmd.fix ? '0 : rem_nx;

	always_ff @(posedge clk) begin
		if (we) begin
			store[wa] <= wd;
		end
		if (cmd.rd_en) begin
			rd_q <= store[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			radix_q <= radix;
			neg10_q <= number[VALUE_W-1] && (radix == RADIX_SIGN);
			quot_q  <= PAD_W'(mag);
			rem_q   <= '0;
		end else if (cmd.div_last) begin
			quot_q <= quot_nx;
			rem_q  <= '0;
		end else if (cmd.div_step) begin
			quot_q <= quot_nx;
			rem_q  <= rem_nx;
		end
		if (cmd.fix) begin
			idx_q <= cnt_zero ? '0 : ADDR_W'(cnt_q - 1'b1);
		end else if (cmd.idx_dec) begin
			idx_q <= idx_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load_in) begin
			cnt_q <= '0;
		end else if (cmd.div_last || (cmd.fix && cnt_zero)) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_bad || cmd.out_sign || cmd.out_digit) begin
			out_valid_q <= 1'b1;
		end else if (char_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		priority if (cmd.out_bad) begin
			char_q <= CHAR_NONE;
			last_q <= 1'b1;
			bad_q  <= 1'b1;
		end else if (cmd.out_sign) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
			bad_q  <= 1'b0;
		end else if (cmd.out_digit) begin
			char_q <= digit_to_char(rd_q);
			last_q <= (idx_q == '0);
			bad_q  <= 1'b0;
		end else begin
			char_q <= char_q;
		end
	end

	assign char_ch.valid     = out_valid_q;
	assign char_ch.char_code = char_q;
	assign char_ch.last      = last_q;
	assign char_ch.bad_radix = bad_q;

	assign sts.bad_radix = (radix_q < RADIX_MIN) || (radix_q > RADIX_MAX);
	assign sts.q_zero    = (quot_q == '0);
	assign sts.cnt_full  = (cnt_q == CNT_W'(VALUE_W));
	assign sts.neg10     = neg10_q;
	assign sts.out_free  = !out_valid_q || char_ch.ready;
	assign sts.idx_zero  = (idx_q == '0);

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_bad || cmd.out_sign || cmd.out_digit) |-> (!out_valid_q || char_ch.ready))
		else $error("Output register loaded while an item is still waiting.");

	a_load_one: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.out_bad, cmd.out_sign, cmd.out_digit}))
		else $error("More than one output load in a cycle.");

	a_store_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_last |-> (cnt_q < CNT_W'(VALUE_W)))
		else $error("Digit written beyond the end of the digit store.");

	a_bad_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && bad_q) |-> (last_q && (char_q == CHAR_NONE)))
		else $error("Rejected radix item is not a single empty last item.");

endmodule

`default_nettype wire

### rtl/signed_int_to_radix_ascii.sv
// Top level of the signed integer to radix ASCII converter.
// Joins sira_ctrl and sira_dp to the channel interfaces of sira_if.sv; uses sira_pkg.
//
// Each input item carries a signed 32-bit value and a radix and produces one output
// item per ASCII character, most significant digit first, with last set on the
// final one. Digits above nine read 'A' to 'V'; a '-' leads only for a negative value
// in radix 10, other radixes print the magnitude, and the most negative value is
// converted as 2^31. Zero gives '0'. A radix outside 2 to 32 gives one item with
// char_code 0, last and bad_radix set. One item is converted at a time: the
// divider retires 8 quotient bits per cycle, and each digit character is read
// from the digit store, then loaded into the output register. The next input
// is accepted once the last character is loaded into the output register.
`default_nettype none

module signed_int_to_radix_ascii
	import sira_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	sira_in_if.sink    value_ch,
	sira_out_if.source char_ch
);

	sira_cmd_t cmd;
	sira_sts_t sts;

	sira_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (value_ch.valid),
		.in_ready (value_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sira_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.number  (value_ch.number),
		.radix   (value_ch.radix),
		.cmd     (cmd),
		.sts     (sts),
		.char_ch (char_ch)
	);

endmodule

`default_nettype wire
